// ===== src/vfcm_pkg.sv =====
`default_nettype none
package vfcm_pkg;

   localparam int GRID_X    = 16;
   localparam int GRID_Y    = 16;
   localparam int GRID_Z    = 16;
   localparam int CUBE_EDGE = 1;

   localparam int SIDE_W = 4;
   localparam int ADDR_W = 3 * SIDE_W;
   localparam int MAT_W  = 3;
   localparam int COORD_W = 5;
   localparam int COLOR_W = 8;
   localparam int NUM_FACES = 6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EMIT  = 1'b1;

   localparam logic [2:0] FACE_NEG_X = 3'd0;
   localparam logic [2:0] FACE_POS_X = 3'd1;
   localparam logic [2:0] FACE_NEG_Y = 3'd2;
   localparam logic [2:0] FACE_POS_Y = 3'd3;
   localparam logic [2:0] FACE_NEG_Z = 3'd4;
   localparam logic [2:0] FACE_POS_Z = 3'd5;

   localparam logic [2:0] CORNER_LAST = 3'd5;
   localparam logic [2:0] PROBE_LAST  = 3'd7;

   localparam logic [MAT_W-1:0] MAT_EMPTY   = 3'd0;
   localparam logic [MAT_W-1:0] MAT_SAND    = 3'd1;
   localparam logic [MAT_W-1:0] MAT_GRASS   = 3'd2;
   localparam logic [MAT_W-1:0] MAT_DIRT    = 3'd3;
   localparam logic [MAT_W-1:0] MAT_STONE   = 3'd4;
   localparam logic [MAT_W-1:0] MAT_SNOW    = 3'd5;
   localparam logic [MAT_W-1:0] MAT_WATER   = 3'd6;
   localparam logic [MAT_W-1:0] MAT_UNKNOWN = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] idx;
   } face_sel_type;

   // Material color lookup.
   function automatic color_type palette(input logic [MAT_W-1:0] mat);
      color_type c;
      case (mat)
         MAT_SAND:    c = '{8'd240, 8'd240, 8'd64};
         MAT_GRASS:   c = '{8'd147, 8'd105, 8'd46};
         MAT_DIRT:    c = '{8'd32,  8'd160, 8'd0};
         MAT_STONE:   c = '{8'd128, 8'd128, 8'd128};
         MAT_SNOW:    c = '{8'd255, 8'd255, 8'd255};
         MAT_WATER:   c = '{8'd0,   8'd0,   8'd255};
         MAT_UNKNOWN: c = '{8'd255, 8'd0,   8'd0};
         default:     c = '{8'd0,   8'd0,   8'd0};
      endcase
      return c;
   endfunction

   // Cube corner code for a face vertex: bit0 = +x, bit1 = +y, bit2 = +z.
   function automatic logic [2:0] face_corner(input logic [2:0] face,
                                              input logic [2:0] k);
      logic [17:0] row;
      case (face)
         FACE_NEG_X: row = {3'd6, 3'd4, 3'd2, 3'd2, 3'd4, 3'd0};
         FACE_POS_X: row = {3'd5, 3'd7, 3'd3, 3'd5, 3'd3, 3'd1};
         FACE_NEG_Y: row = {3'd4, 3'd5, 3'd1, 3'd4, 3'd1, 3'd0};
         FACE_POS_Y: row = {3'd7, 3'd6, 3'd3, 3'd3, 3'd6, 3'd2};
         FACE_NEG_Z: row = {3'd1, 3'd3, 3'd2, 3'd1, 3'd2, 3'd0};
         FACE_POS_Z: row = {3'd7, 3'd5, 3'd6, 3'd6, 3'd5, 3'd4};
         default:    row = '0;
      endcase
      case (k)
         3'd0:    return row[2:0];
         3'd1:    return row[5:3];
         3'd2:    return row[8:6];
         3'd3:    return row[11:9];
         3'd4:    return row[14:12];
         3'd5:    return row[17:15];
         default: return 3'd0;
      endcase
   endfunction

   // Lowest visible face at or above a starting face.
   function automatic face_sel_type next_face(input logic [NUM_FACES-1:0] mask,
                                              input logic [3:0] from);
      face_sel_type sel;
      sel.hit = 1'b0;
      sel.idx = 3'd0;
      for (int i = 0; i < NUM_FACES; i++) begin
         if (!sel.hit && mask[i] && (4'(i) >= from)) begin
            sel.hit = 1'b1;
            sel.idx = 3'(i);
         end
      end
      return sel;
   endfunction

endpackage
`default_nettype wire

// ===== src/voxel_face_cull_mesher_core.sv =====
`default_nettype none
// Voxel face culling mesher. Holds a 16x16x16 grid of 3-bit material codes in a
// single-port-write, single-port-read RAM with registered read data (contents are
// undefined until written). A write item goes straight into the RAM. An emit item
// is accepted, then looked up: seven reads through the RAM read port (the voxel
// itself, then its six neighbors) and one more step for the last read data. It
// then sends one vertex per cycle while the output is not stalled, six per visible
// face, faces in -x, +x, -y, +y, -z, +z order, with last set on the final vertex.
// An empty voxel or a voxel with no visible face produces no transfer. The input is
// stalled while an emit is in progress; the result register lets the next item be
// taken while the final vertex still waits.
module voxel_face_cull_mesher_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_op,
   input  wire logic [3:0] req_pos_x,
   input  wire logic [3:0] req_pos_y,
   input  wire logic [3:0] req_pos_z,
   input  wire logic [2:0] req_material,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [4:0]      rsp_vert_x,
   output logic [4:0]      rsp_vert_y,
   output logic [4:0]      rsp_vert_z,
   output logic [7:0]      rsp_red,
   output logic [7:0]      rsp_green,
   output logic [7:0]      rsp_blue,
   output logic            rsp_last
);

   localparam int DEPTH = 1 << vfcm_pkg::ADDR_W;

   logic [vfcm_pkg::MAT_W-1:0] voxel_mem [DEPTH];

   vfcm_pkg::state_type state_ff, state_in;
   logic [3:0] pos_x_ff, pos_x_in;
   logic [3:0] pos_y_ff, pos_y_in;
   logic [3:0] pos_z_ff, pos_z_in;
   logic [2:0] probe_ff, probe_in;
   logic [vfcm_pkg::MAT_W-1:0] mat_ff, mat_in;
   logic [vfcm_pkg::NUM_FACES-1:0] mask_ff, mask_in;
   logic [2:0] face_ff, face_in;
   logic [2:0] corner_ff, corner_in;
   logic [vfcm_pkg::MAT_W-1:0] rd_data_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] vert_x_ff, vert_x_in;
   logic [4:0] vert_y_ff, vert_y_in;
   logic [4:0] vert_z_ff, vert_z_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;
   logic [7:0] blue_ff, blue_in;
   logic       last_ff, last_in;

   logic accept;
   logic pos_inside;
   logic mem_we;
   logic [vfcm_pkg::ADDR_W-1:0] mem_waddr;
   logic [vfcm_pkg::ADDR_W-1:0] mem_raddr;
   logic [2:0] done_idx;
   logic [2:0] done_face;
   logic [2:0] probe_face;
   logic [vfcm_pkg::NUM_FACES-1:0] mask_now;
   logic [vfcm_pkg::NUM_FACES-1:0] nb_inside;
   logic [3:0] nb_x, nb_y, nb_z;
   logic out_free;
   logic [2:0] corner;
   vfcm_pkg::color_type color;
   vfcm_pkg::face_sel_type first_sel;
   vfcm_pkg::face_sel_type after_sel;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != vfcm_pkg::ST_IDLE);
   assign pos_inside = (int'(req_pos_x) < vfcm_pkg::GRID_X) &&
                       (int'(req_pos_y) < vfcm_pkg::GRID_Y) &&
                       (int'(req_pos_z) < vfcm_pkg::GRID_Z);
   assign mem_we     = accept && (req_op == vfcm_pkg::OP_WRITE) && pos_inside;
   assign mem_waddr  = {req_pos_z, req_pos_y, req_pos_x};

   // Neighbor lies inside the grid, per face.
   assign nb_inside[vfcm_pkg::FACE_NEG_X] = (pos_x_ff != 4'd0);
   assign nb_inside[vfcm_pkg::FACE_POS_X] = (pos_x_ff != 4'd15) &&
                                            (int'(pos_x_ff) + 1 < vfcm_pkg::GRID_X);
   assign nb_inside[vfcm_pkg::FACE_NEG_Y] = (pos_y_ff != 4'd0);
   assign nb_inside[vfcm_pkg::FACE_POS_Y] = (pos_y_ff != 4'd15) &&
                                            (int'(pos_y_ff) + 1 < vfcm_pkg::GRID_Y);
   assign nb_inside[vfcm_pkg::FACE_NEG_Z] = (pos_z_ff != 4'd0);
   assign nb_inside[vfcm_pkg::FACE_POS_Z] = (pos_z_ff != 4'd15) &&
                                            (int'(pos_z_ff) + 1 < vfcm_pkg::GRID_Z);

   // Read address: probe 0 is the voxel itself, probe f+1 the neighbor of face f.
   always_comb begin
      probe_face = probe_ff - 3'd1;
      nb_x = pos_x_ff;
      nb_y = pos_y_ff;
      nb_z = pos_z_ff;
      if (probe_ff != 3'd0) begin
         case (probe_face)
            vfcm_pkg::FACE_NEG_X: nb_x = pos_x_ff - 4'd1;
            vfcm_pkg::FACE_POS_X: nb_x = pos_x_ff + 4'd1;
            vfcm_pkg::FACE_NEG_Y: nb_y = pos_y_ff - 4'd1;
            vfcm_pkg::FACE_POS_Y: nb_y = pos_y_ff + 4'd1;
            vfcm_pkg::FACE_NEG_Z: nb_z = pos_z_ff - 4'd1;
            vfcm_pkg::FACE_POS_Z: nb_z = pos_z_ff + 4'd1;
            default: ;
         endcase
      end
      mem_raddr = {nb_z, nb_y, nb_x};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         voxel_mem[mem_waddr] <= req_material;
      end
      rd_data_ff <= voxel_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vfcm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      pos_z_ff  <= pos_z_in;
      probe_ff  <= probe_in;
      mat_ff    <= mat_in;
      mask_ff   <= mask_in;
      face_ff   <= face_in;
      corner_ff <= corner_in;
      vert_x_ff <= vert_x_in;
      vert_y_ff <= vert_y_in;
      vert_z_ff <= vert_z_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in     = state_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;
      probe_in     = probe_ff;
      mat_in       = mat_ff;
      mask_in      = mask_ff;
      face_in      = face_ff;
      corner_in    = corner_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      vert_x_in    = vert_x_ff;
      vert_y_in    = vert_y_ff;
      vert_z_in    = vert_z_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      last_in      = last_ff;

      out_free  = !rsp_valid_ff || !rsp_stall;
      done_idx  = probe_ff - 3'd1;
      done_face = probe_ff - 3'd2;
      mask_now  = mask_ff;
      if (probe_ff >= 3'd2) begin
         mask_now[done_face] = !nb_inside[done_face] || (rd_data_ff == vfcm_pkg::MAT_EMPTY);
      end
      first_sel = vfcm_pkg::next_face(mask_now, 4'd0);
      after_sel = vfcm_pkg::next_face(mask_ff, {1'b0, face_ff} + 4'd1);

      corner = vfcm_pkg::face_corner(face_ff, corner_ff);
      color  = vfcm_pkg::palette(mat_ff);

      case (state_ff)
         vfcm_pkg::ST_IDLE: begin
            if (accept && (req_op == vfcm_pkg::OP_EMIT) && pos_inside) begin
               pos_x_in = req_pos_x;
               pos_y_in = req_pos_y;
               pos_z_in = req_pos_z;
               probe_in = 3'd0;
               mask_in  = '0;
               state_in = vfcm_pkg::ST_FETCH;
            end
         end
         vfcm_pkg::ST_FETCH: begin
            // Read data is registered, so it belongs to the previous probe: consume that one.
            if (probe_ff != 3'd0) begin
               if (done_idx == 3'd0) begin
                  mat_in = rd_data_ff;
               end else begin
                  mask_in = mask_now;
               end
            end
            probe_in = probe_ff + 3'd1;
            if (probe_ff == vfcm_pkg::PROBE_LAST) begin
               if ((mat_ff == vfcm_pkg::MAT_EMPTY) || !first_sel.hit) begin
                  state_in = vfcm_pkg::ST_IDLE;
               end else begin
                  face_in   = first_sel.idx;
                  corner_in = 3'd0;
                  state_in  = vfcm_pkg::ST_EMIT;
               end
            end
         end
         vfcm_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               vert_x_in = {1'b0, pos_x_ff} + (corner[0] ? 5'(vfcm_pkg::CUBE_EDGE) : 5'd0);
               vert_y_in = {1'b0, pos_y_ff} + (corner[1] ? 5'(vfcm_pkg::CUBE_EDGE) : 5'd0);
               vert_z_in = {1'b0, pos_z_ff} + (corner[2] ? 5'(vfcm_pkg::CUBE_EDGE) : 5'd0);
               if (face_ff == vfcm_pkg::FACE_POS_Z) begin
                  red_in   = color.red;
                  green_in = color.green;
                  blue_in  = color.blue;
               end else begin
                  red_in   = color.red >> 1;
                  green_in = color.green >> 1;
                  blue_in  = color.blue >> 1;
               end
               last_in = (corner_ff == vfcm_pkg::CORNER_LAST) && !after_sel.hit;
               if (corner_ff != vfcm_pkg::CORNER_LAST) begin
                  corner_in = corner_ff + 3'd1;
               end else if (after_sel.hit) begin
                  corner_in = 3'd0;
                  face_in   = after_sel.idx;
               end else begin
                  state_in = vfcm_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = vfcm_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vert_x = vert_x_ff;
   assign rsp_vert_y = vert_y_ff;
   assign rsp_vert_z = vert_z_ff;
   assign rsp_red    = red_ff;
   assign rsp_green  = green_ff;
   assign rsp_blue   = blue_ff;
   assign rsp_last   = last_ff;

endmodule
`default_nettype wire
